// File: rtl/mcpid_pkg.sv
// Shared widths, codes and command structs of the multi-channel PID controller.
package mcpid_pkg;

  localparam int DATA_W         = 32;
  localparam int ERR_W          = DATA_W + 1;
  localparam int INTEG_W        = 48;
  localparam int DT_FRAC        = 24;
  localparam int Q_FRAC         = 16;
  localparam int OPND_W         = DATA_W + 1;
  localparam int PROD_W         = 2 * OPND_W;
  localparam int INC_W          = PROD_W - DT_FRAC;
  localparam int QUO_W          = ERR_W + 1 + DT_FRAC;
  localparam int DERIV_W        = QUO_W + 1;
  localparam int ACC_W          = 96;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = QUO_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int NUM_CH_W       = 4;
  localparam int CH_W           = 3;
  localparam int REG_IDX_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd3;

  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic signed [DATA_W-1:0] PROP_GAIN_RST  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] INTEG_GAIN_RST = 32'sd0;
  localparam logic signed [DATA_W-1:0] DERIV_GAIN_RST = 32'sd0;
  localparam logic [NUM_CH_W-1:0]      NUM_CH_RST     = 4'd1;

  // multiply-accumulate command
  typedef struct packed {
    logic valid;
    logic acc;
    logic first;
    logic hi;
  } mac_cmd_t;

  // state store command
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } st_cmd_t;

endpackage

// File: rtl/mcpid_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module mcpid_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mcpid_pkg::QUO_W-1:0]  dividend,
  input  logic [mcpid_pkg::DATA_W-1:0] divisor,
  output logic                         busy,
  output logic [mcpid_pkg::QUO_W-1:0]  quotient
);

  logic [mcpid_pkg::QUO_W-1:0]     num;
  logic [mcpid_pkg::QUO_W-1:0]     num_next;
  logic [mcpid_pkg::DATA_W-1:0]    rem;
  logic [mcpid_pkg::DATA_W-1:0]    rem_next;
  logic [mcpid_pkg::DATA_W-1:0]    dvs;
  logic [mcpid_pkg::DIV_CNT_W-1:0] cnt;

  always_comb begin
    logic [mcpid_pkg::DATA_W:0] trial;
    rem_next = rem;
    num_next = num;
    trial    = '0;
    for (int k = 0; k < mcpid_pkg::DIV_RADIX_BITS; k++) begin
      trial    = {rem_next, num_next[mcpid_pkg::QUO_W-1]};
      num_next = {num_next[mcpid_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        num_next[0] = 1'b1;
      end
      rem_next = trial[mcpid_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= mcpid_pkg::DIV_CNT_W'(mcpid_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - mcpid_pkg::DIV_CNT_W'(1);
      if (cnt == mcpid_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quotient = num;

endmodule

// File: rtl/mcpid_mac.sv
// Shared 33x33 signed multiplier with a wide accumulator behind it.
module mcpid_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  mcpid_pkg::mac_cmd_t                 cmd,
  input  logic signed [mcpid_pkg::OPND_W-1:0] op_a,
  input  logic signed [mcpid_pkg::OPND_W-1:0] op_b,
  output logic signed [mcpid_pkg::PROD_W-1:0] prod,
  output logic signed [mcpid_pkg::ACC_W-1:0]  acc
);

  mcpid_pkg::mac_cmd_t               cmd_q;
  logic [mcpid_pkg::ACC_W-1:0]       prod_ext;
  logic [mcpid_pkg::ACC_W-1:0]       addend;

  assign prod_ext = {{(mcpid_pkg::ACC_W - mcpid_pkg::PROD_W){prod[mcpid_pkg::PROD_W-1]}}, prod};
  assign addend   = cmd_q.hi ? (prod_ext << mcpid_pkg::DATA_W) : prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      prod <= op_a * op_b;
    end
    if (cmd_q.valid && cmd_q.acc) begin
      acc <= $signed((cmd_q.first ? '0 : acc) + addend);
    end
  end

endmodule

// File: rtl/mcpid_store.sv
// Per-channel last error and integral store with valid bits.
module mcpid_store #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mcpid_pkg::st_cmd_t            cmd,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [mcpid_pkg::ERR_W-1:0]   wr_last,
  input  logic [mcpid_pkg::INTEG_W-1:0] wr_integ,
  output logic [mcpid_pkg::ERR_W-1:0]   rd_last,
  output logic [mcpid_pkg::INTEG_W-1:0] rd_integ
);

  logic [mcpid_pkg::ERR_W-1:0]   last_mem  [DEPTH];
  logic [mcpid_pkg::INTEG_W-1:0] integ_mem [DEPTH];
  logic [DEPTH-1:0]              vld;
  logic                          rd_vld;
  logic [mcpid_pkg::ERR_W-1:0]   last_q;
  logic [mcpid_pkg::INTEG_W-1:0] integ_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld <= '0;
      end else if (cmd.wr) begin
        vld[wr_idx] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_vld <= vld[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      last_mem[wr_idx]  <= wr_last;
      integ_mem[wr_idx] <= wr_integ;
    end
    if (cmd.rd) begin
      last_q  <= last_mem[rd_idx];
      integ_q <= integ_mem[rd_idx];
    end
  end

  assign rd_last  = rd_vld ? last_q : '0;
  assign rd_integ = rd_vld ? integ_q : '0;

endmodule

// File: rtl/multi_channel_pid_controller.sv
// Multi-channel PID controller top level: config registers, sequencer and result register.
//
// A control step runs the divider that forms the derivative, which yields two quotient
// bits a cycle, and the six products share one multiplier around it. An out-of-range
// channel answers with a flagged zero-drive result, and a clear item gives no result.
// step_stall is high from the transfer of a step until its result is loaded into the
// output register; that register holds one finished result while the next item is taken.
// Stored state clears at reset.
module multi_channel_pid_controller #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mcpid_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mcpid_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                 step_valid,
  output logic                                 step_stall,
  input  logic                                 func,
  input  logic [mcpid_pkg::CH_W-1:0]           channel,
  input  logic signed [mcpid_pkg::DATA_W-1:0]  reference,
  input  logic signed [mcpid_pkg::DATA_W-1:0]  measurement,
  input  logic [mcpid_pkg::DATA_W-1:0]         time_step,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [mcpid_pkg::CH_W-1:0]           out_channel,
  output logic signed [mcpid_pkg::DATA_W-1:0]  drive,
  output logic                                 bad_channel
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DW    = mcpid_pkg::DATA_W;
  localparam int EW    = mcpid_pkg::ERR_W;
  localparam int IW    = mcpid_pkg::INTEG_W;
  localparam int OW    = mcpid_pkg::OPND_W;
  localparam int DVW   = mcpid_pkg::DERIV_W;
  localparam int AW    = mcpid_pkg::ACC_W;
  localparam int HI_W  = AW - mcpid_pkg::Q_FRAC - DW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_INC, S_G_IL, S_G_IH, S_WAIT, S_D_LO, S_D_HI, S_DRAIN, S_FIN
  } state_t;

  state_t                                state;
  logic signed [DW-1:0]                  prop_gain;
  logic signed [DW-1:0]                  integ_gain;
  logic signed [DW-1:0]                  deriv_gain;
  logic [mcpid_pkg::NUM_CH_W-1:0]        num_channels;

  logic [mcpid_pkg::CH_W-1:0]            ch_q;
  logic                                  bad_q;
  logic [DW-1:0]                         dt_q;
  logic                                  dt_zero;
  logic signed [EW-1:0]                  err;
  logic                                  dneg;
  logic [IW-1:0]                         integ_new;
  logic [DVW-1:0]                        deriv;

  logic                                  accept;
  logic                                  in_bad;
  logic                                  out_free;
  logic signed [EW:0]                    diff;
  logic [EW:0]                           diff_mag;
  logic [mcpid_pkg::INC_W-1:0]           inc;
  logic [IW:0]                           integ_sum;
  logic [IW-1:0]                         integ_sat;
  logic [DVW-1:0]                        deriv_mag;
  logic [DVW-1:0]                        deriv_calc;
  logic [HI_W-1:0]                       acc_hi;
  logic [DW-1:0]                         drive_sat;

  mcpid_pkg::mac_cmd_t                   mac_cmd;
  logic signed [OW-1:0]                  mac_a;
  logic signed [OW-1:0]                  mac_b;
  logic signed [mcpid_pkg::PROD_W-1:0]   mac_prod;
  logic signed [AW-1:0]                  mac_acc;

  mcpid_pkg::st_cmd_t                    st_cmd;
  logic [EW-1:0]                         rd_last;
  logic [IW-1:0]                         rd_integ;

  logic                                  div_start;
  logic                                  div_busy;
  logic [mcpid_pkg::QUO_W-1:0]           quotient;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= mcpid_pkg::PROP_GAIN_RST;
      integ_gain   <= mcpid_pkg::INTEG_GAIN_RST;
      deriv_gain   <= mcpid_pkg::DERIV_GAIN_RST;
      num_channels <= mcpid_pkg::NUM_CH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcpid_pkg::REG_PROP_GAIN:    prop_gain    <= $signed(cfg_data);
        mcpid_pkg::REG_INTEG_GAIN:   integ_gain   <= $signed(cfg_data);
        mcpid_pkg::REG_DERIV_GAIN:   deriv_gain   <= $signed(cfg_data);
        mcpid_pkg::REG_NUM_CHANNELS: num_channels <= cfg_data[mcpid_pkg::NUM_CH_W-1:0];
      endcase
    end
  end

  assign step_stall = (state != S_IDLE);
  assign accept     = step_valid && !step_stall;
  assign out_free   = !result_valid || !result_stall;
  assign in_bad     = ({1'b0, channel} >= num_channels) ||
                      (32'(channel) >= 32'(MAX_CHANNELS));

  // error difference and divider operand
  assign diff      = $signed({err[EW-1], err}) - $signed({rd_last[EW-1], rd_last});
  assign diff_mag  = diff[EW] ? (~diff + 1'b1) : diff;
  assign div_start = (state == S_DIFF) && !dt_zero;

  // integral update: floor of e*dt / 2^24, saturated to 48 bits
  assign inc       = mac_prod[mcpid_pkg::PROD_W-1:mcpid_pkg::DT_FRAC];
  assign integ_sum = {rd_integ[IW-1], rd_integ} +
                     {{(IW + 1 - mcpid_pkg::INC_W){inc[mcpid_pkg::INC_W-1]}}, inc};
  always_comb begin
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_sat = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[IW-1:0];
    end
  end

  assign deriv_mag  = {1'b0, quotient};
  assign deriv_calc = dt_zero ? '0 : (dneg ? (~deriv_mag + 1'b1) : deriv_mag);

  // drive: Q.32 sum down to Q16.16 with saturation
  assign acc_hi = mac_acc[AW-1:mcpid_pkg::Q_FRAC+DW-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      drive_sat = mac_acc[mcpid_pkg::Q_FRAC+DW-1:mcpid_pkg::Q_FRAC];
    end else begin
      drive_sat = mac_acc[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mac_cmd = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state)
      S_DIFF: begin
        mac_cmd.valid = 1'b1;
        mac_a         = err;
        mac_b         = $signed({1'b0, dt_q});
      end
      S_INC: begin
        mac_cmd = '{valid: 1'b1, acc: 1'b1, first: 1'b1, hi: 1'b0};
        mac_a   = $signed({prop_gain[DW-1], prop_gain});
        mac_b   = err;
      end
      S_G_IL: begin
        mac_cmd = '{valid: 1'b1, acc: 1'b1, first: 1'b0, hi: 1'b0};
        mac_a   = $signed({integ_gain[DW-1], integ_gain});
        mac_b   = $signed({1'b0, integ_new[DW-1:0]});
      end
      S_G_IH: begin
        mac_cmd = '{valid: 1'b1, acc: 1'b1, first: 1'b0, hi: 1'b1};
        mac_a   = $signed({integ_gain[DW-1], integ_gain});
        mac_b   = $signed({{(OW - IW + DW){integ_new[IW-1]}}, integ_new[IW-1:DW]});
      end
      S_D_LO: begin
        mac_cmd = '{valid: 1'b1, acc: 1'b1, first: 1'b0, hi: 1'b0};
        mac_a   = $signed({deriv_gain[DW-1], deriv_gain});
        mac_b   = $signed({1'b0, deriv[DW-1:0]});
      end
      S_D_HI: begin
        mac_cmd = '{valid: 1'b1, acc: 1'b1, first: 1'b0, hi: 1'b1};
        mac_a   = $signed({deriv_gain[DW-1], deriv_gain});
        mac_b   = $signed({{(OW - DVW + DW){deriv[DVW-1]}}, deriv[DVW-1:DW]});
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  assign st_cmd.clr = accept && (func == mcpid_pkg::FUNC_CLEAR);
  assign st_cmd.rd  = accept && (func == mcpid_pkg::FUNC_STEP) && !in_bad;
  assign st_cmd.wr  = (state == S_G_IH);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch_q    <= channel;
            bad_q   <= in_bad;
            dt_q    <= time_step;
            dt_zero <= (time_step == '0);
            err     <= $signed({reference[DW-1], reference}) -
                       $signed({measurement[DW-1], measurement});
            if (func == mcpid_pkg::FUNC_CLEAR) begin
              state <= S_IDLE;
            end else if (in_bad) begin
              state <= S_FIN;
            end else begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          dneg  <= diff[EW];
          state <= S_INC;
        end
        S_INC: begin
          integ_new <= integ_sat;
          state     <= S_G_IL;
        end
        S_G_IL:  state <= S_G_IH;
        S_G_IH:  state <= S_WAIT;
        S_WAIT: begin
          if (!div_busy) begin
            deriv <= deriv_calc;
            state <= S_D_LO;
          end
        end
        S_D_LO:  state <= S_D_HI;
        S_D_HI:  state <= S_DRAIN;
        S_DRAIN: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            out_channel  <= ch_q;
            drive        <= bad_q ? '0 : $signed(drive_sat);
            bad_channel  <= bad_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mcpid_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  mcpid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, {mcpid_pkg::DT_FRAC{1'b0}}}),
    .divisor  (dt_q),
    .busy     (div_busy),
    .quotient (quotient)
  );

  mcpid_store #(
    .DEPTH (MAX_CHANNELS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (st_cmd),
    .rd_idx   (IDX_W'(channel)),
    .wr_idx   (IDX_W'(ch_q)),
    .wr_last  (err),
    .wr_integ (integ_new),
    .rd_last  (rd_last),
    .rd_integ (rd_integ)
  );

  a_bad_zero_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_channel |-> drive == '0)
    else $error("flagged channel with nonzero drive");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == S_D_LO |-> !div_busy)
    else $error("derivative used before divider finished");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    st_cmd.wr |-> !bad_q)
    else $error("state written for out-of-range channel");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && func == mcpid_pkg::FUNC_CLEAR |=> state == S_IDLE)
    else $error("clear transfer started a computation");

endmodule
